/* rtl/core/vmv_pkg.sv */
// ----------------------------------------------------------------------------
// vmv_pkg
// Shared widths, types and register indexes for the model-view vertex
// transform pipeline.
// ----------------------------------------------------------------------------
package vmv_pkg;

	// Field widths
	localparam int POS_W      = 20;   // Q12.8 position
	localparam int QUAT_W     = 16;   // Q1.14 quaternion component
	localparam int COLOR_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Matrix and datapath widths
	localparam int QPROD_W = 2 * QUAT_W;          // product of two components, Q.28
	localparam int MAT_W   = QPROD_W + 2;         // matrix entry, Q.28
	localparam int VEC_W   = 29;                  // vector element entering a rotation
	localparam int PROD_W  = MAT_W + VEC_W;       // entry times element, Q.36
	localparam int ACC_W   = PROD_W + 2;          // row sum
	localparam int FRAC_SH = 28;                  // Q.36 -> Q.8
	localparam int RES_W   = ACC_W - FRAC_SH;     // rounded row result
	localparam int ROT_W   = 28;                  // model-rotated element range

	typedef logic signed [MAT_W-1:0] coef_t;
	typedef coef_t mat_t [3][3];

	typedef logic signed [VEC_W-1:0] vec_elem_t;
	typedef vec_elem_t vec_t [3];

	typedef logic signed [RES_W-1:0] res_elem_t;
	typedef res_elem_t res_t [3];

	// Stage load enables of one rotation unit
	typedef struct packed {
		logic prod;
		logic sum;
	} mv_en_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} color_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODEL_QUAT    = 3'd0,
		REG_CAMERA_QUAT   = 3'd1,
		REG_MODEL_OFFSET  = 3'd2,
		REG_CAMERA_OFFSET = 3'd3,
		REG_RECOLOR       = 3'd4,
		REG_FIXED_COLOR   = 3'd5
	} cfg_reg_t;

endpackage

/* rtl/core/vertex_model_view_transform.sv */
// ----------------------------------------------------------------------------
// vertex_model_view_transform
// Model-view transform of one vertex per transfer: model rotation, model
// and camera offsets, inverse camera rotation, colour pass or replace.
// ----------------------------------------------------------------------------
// Accepts one vertex every clock unless the output stalls or a configuration
// write is settling; a stalled output holds the pipeline in place without
// loss. Each rotation matrix is rebuilt from its quaternion register through
// two register steps, so in_ready stays low in the cycle of a configuration
// write and until the settle counter has run down, also after reset. The
// camera-space result leaves from the output register. Positions are Q12.8,
// rounded after each rotation and saturated only at the output.
module vertex_model_view_transform import vmv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [POS_W-1:0]  in_x,
	input  logic signed [POS_W-1:0]  in_y,
	input  logic signed [POS_W-1:0]  in_z,
	input  logic [COLOR_W-1:0]       in_red,
	input  logic [COLOR_W-1:0]       in_green,
	input  logic [COLOR_W-1:0]       in_blue,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  view_x,
	output logic signed [POS_W-1:0]  view_y,
	output logic signed [POS_W-1:0]  view_z,
	output logic [COLOR_W-1:0]       out_red,
	output logic [COLOR_W-1:0]       out_green,
	output logic [COLOR_W-1:0]       out_blue
);

	localparam logic [1:0] SETTLE_CYCLES = 2'd2;
	localparam logic [4*QUAT_W-1:0] QUAT_IDENTITY = (4*QUAT_W)'(1) << (QUAT_W - 2);

	// Configuration registers
	logic [4*QUAT_W-1:0]   model_quat_q, camera_quat_q;
	logic [3*POS_W-1:0]    model_offset_q, camera_offset_q;
	logic                  recolor_q;
	color_t                fixed_color_q;
	logic [1:0]            settle_q;

	// Pipeline control
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                  rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	logic                  in_xfer;

	// Datapath
	mat_t                  model_mat, cam_raw, cam_mat;
	vec_t                  in_vec, rel_s3;
	res_t                  rot, view;
	mv_en_t                mv_model_en, mv_cam_en;
	color_t                col_in;
	color_t                col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;
	logic signed [POS_W-1:0] vx_s6, vy_s6, vz_s6;
	logic signed [ROT_W-1:0] rot_e [3];
	logic signed [POS_W-1:0] mo_e [3], co_e [3];

	function automatic logic signed [POS_W-1:0] sat_pos(input res_elem_t v);
		logic all_one;
		logic all_zero;
		all_one  = &v[RES_W-1:POS_W-1];
		all_zero = ~|v[RES_W-1:POS_W-1];
		if (v[RES_W-1] && !all_one) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end else if (!v[RES_W-1] && !all_zero) begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end
		return signed'(v[POS_W-1:0]);
	endfunction

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_quat_q    <= QUAT_IDENTITY;
			camera_quat_q   <= QUAT_IDENTITY;
			model_offset_q  <= '0;
			camera_offset_q <= '0;
			recolor_q       <= 1'b0;
			fixed_color_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODEL_QUAT:    model_quat_q    <= cfg_data[4*QUAT_W-1:0];
				REG_CAMERA_QUAT:   camera_quat_q   <= cfg_data[4*QUAT_W-1:0];
				REG_MODEL_OFFSET:  model_offset_q  <= cfg_data[3*POS_W-1:0];
				REG_CAMERA_OFFSET: camera_offset_q <= cfg_data[3*POS_W-1:0];
				REG_RECOLOR:       recolor_q       <= cfg_data[0];
				REG_FIXED_COLOR:   fixed_color_q   <= cfg_data[3*COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold off input until both matrices reflect the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// Rotation matrices; the conjugate's matrix is the transpose
	vmv_quat_matrix u_model_mat (
		.clk  (clk),
		.quat (model_quat_q),
		.mat  (model_mat)
	);

	vmv_quat_matrix u_cam_mat (
		.clk  (clk),
		.quat (camera_quat_q),
		.mat  (cam_raw)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cam_mat[i][j] = cam_raw[j][i];
			end
		end
	end

	// Ready chain: a stage loads when empty or when its successor moves
	assign rdy6     = !vld_s6 || out_ready;
	assign rdy5     = !vld_s5 || rdy6;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1 && (settle_q == 2'd0) && !cfg_we;
	assign in_xfer  = in_valid && in_ready;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_xfer;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// Stages 1-2: model rotation
	assign in_vec[0]         = VEC_W'(in_x);
	assign in_vec[1]         = VEC_W'(in_y);
	assign in_vec[2]         = VEC_W'(in_z);
	assign mv_model_en.prod  = rdy1;
	assign mv_model_en.sum   = rdy2;

	vmv_mat_vec u_model_rot (
		.clk (clk),
		.en  (mv_model_en),
		.mat (model_mat),
		.vec (in_vec),
		.res (rot)
	);

	// Stage 3: add model offset, subtract camera offset
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rot_e[i] = signed'(rot[i][ROT_W-1:0]);
			mo_e[i]  = signed'(model_offset_q[POS_W*i +: POS_W]);
			co_e[i]  = signed'(camera_offset_q[POS_W*i +: POS_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int i = 0; i < 3; i++) begin
				rel_s3[i] <= VEC_W'(rot_e[i]) + VEC_W'(mo_e[i]) - VEC_W'(co_e[i]);
			end
		end
	end

	// Stages 4-5: inverse camera rotation
	assign mv_cam_en.prod = rdy4;
	assign mv_cam_en.sum  = rdy5;

	vmv_mat_vec u_cam_rot (
		.clk (clk),
		.en  (mv_cam_en),
		.mat (cam_mat),
		.vec (rel_s3),
		.res (view)
	);

	// Stage 6: saturate into the output register
	always_ff @(posedge clk) begin
		if (rdy6) begin
			vx_s6 <= sat_pos(view[0]);
			vy_s6 <= sat_pos(view[1]);
			vz_s6 <= sat_pos(view[2]);
		end
	end

	// Colour: pick at entry, then carry alongside the position
	assign col_in = recolor_q ? fixed_color_q : color_t'({in_blue, in_green, in_red});

	always_ff @(posedge clk) begin
		if (rdy1) col_s1 <= col_in;
		if (rdy2) col_s2 <= col_s1;
		if (rdy3) col_s3 <= col_s2;
		if (rdy4) col_s4 <= col_s3;
		if (rdy5) col_s5 <= col_s4;
		if (rdy6) col_s6 <= col_s5;
	end

	assign out_valid = vld_s6;
	assign view_x    = vx_s6;
	assign view_y    = vy_s6;
	assign view_z    = vz_s6;
	assign out_red   = col_s6.red;
	assign out_green = col_s6.green;
	assign out_blue  = col_s6.blue;

endmodule

/* rtl/core/vmv_quat_matrix.sv */
// ----------------------------------------------------------------------------
// vmv_quat_matrix
// Builds the Q.28 rotation matrix of a packed Q1.14 quaternion in two
// register steps: component products, then matrix entries.
// ----------------------------------------------------------------------------
module vmv_quat_matrix import vmv_pkg::*; (
	input  logic                  clk,
	input  logic [4*QUAT_W-1:0]   quat,
	output mat_t                  mat
);

	localparam coef_t ONE_Q = MAT_W'(1) << FRAC_SH;

	logic signed [QUAT_W-1:0]  qw, qx, qy, qz;
	logic signed [QPROD_W-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [QPROD_W-1:0] wx_s1, wy_s1, wz_s1;
	coef_t                     xx, yy, zz, xy, xz, yz, wx, wy, wz;
	mat_t                      mat_s2;

	// Unpack components, w lowest
	assign qw = signed'(quat[0*QUAT_W +: QUAT_W]);
	assign qx = signed'(quat[1*QUAT_W +: QUAT_W]);
	assign qy = signed'(quat[2*QUAT_W +: QUAT_W]);
	assign qz = signed'(quat[3*QUAT_W +: QUAT_W]);

	// Register the component products
	always_ff @(posedge clk) begin
		xx_s1 <= qx * qx;
		yy_s1 <= qy * qy;
		zz_s1 <= qz * qz;
		xy_s1 <= qx * qy;
		xz_s1 <= qx * qz;
		yz_s1 <= qy * qz;
		wx_s1 <= qw * qx;
		wy_s1 <= qw * qy;
		wz_s1 <= qw * qz;
	end

	// Widen products to entry width
	always_comb begin
		xx = MAT_W'(xx_s1);
		yy = MAT_W'(yy_s1);
		zz = MAT_W'(zz_s1);
		xy = MAT_W'(xy_s1);
		xz = MAT_W'(xz_s1);
		yz = MAT_W'(yz_s1);
		wx = MAT_W'(wx_s1);
		wy = MAT_W'(wy_s1);
		wz = MAT_W'(wz_s1);
	end

	// Form the entries by the standard quaternion formula
	always_ff @(posedge clk) begin
		mat_s2[0][0] <= ONE_Q - ((yy + zz) <<< 1);
		mat_s2[0][1] <= (xy - wz) <<< 1;
		mat_s2[0][2] <= (xz + wy) <<< 1;
		mat_s2[1][0] <= (xy + wz) <<< 1;
		mat_s2[1][1] <= ONE_Q - ((xx + zz) <<< 1);
		mat_s2[1][2] <= (yz - wx) <<< 1;
		mat_s2[2][0] <= (xz - wy) <<< 1;
		mat_s2[2][1] <= (yz + wx) <<< 1;
		mat_s2[2][2] <= ONE_Q - ((xx + yy) <<< 1);
	end

	assign mat = mat_s2;

endmodule

/* rtl/core/vmv_mat_vec.sv */
// ----------------------------------------------------------------------------
// vmv_mat_vec
// Two-stage 3x3 matrix times vector unit: nine registered products, then
// row sums rounded from Q.36 to Q.8 (half toward plus infinity).
// ----------------------------------------------------------------------------
module vmv_mat_vec import vmv_pkg::*; (
	input  logic   clk,
	input  mv_en_t en,
	input  mat_t   mat,
	input  vec_t   vec,
	output res_t   res
);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SH - 1);

	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [ACC_W-1:0]  acc [3];
	res_t                     sum_s2;

	// Register the nine products
	always_ff @(posedge clk) begin
		if (en.prod) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= mat[i][j] * vec[j];
				end
			end
		end
	end

	// Sum each row and add the rounding half
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(prod_s1[i][0]) + ACC_W'(prod_s1[i][1])
				+ ACC_W'(prod_s1[i][2]) + ROUND_HALF;
		end
	end

	// Drop the fraction: the arithmetic shift floors
	always_ff @(posedge clk) begin
		if (en.sum) begin
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= signed'(acc[i][ACC_W-1:FRAC_SH]);
			end
		end
	end

	assign res = sum_s2;

endmodule

/* rtl/core/vmv_checker.sv */
// ----------------------------------------------------------------------------
// vmv_checker
// Port-level checks of the vertex transform: input hold-off around
// configuration writes, free flow when the output is empty, output hold.
// ----------------------------------------------------------------------------
module vmv_checker import vmv_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [POS_W-1:0]  view_x,
	input logic signed [POS_W-1:0]  view_y,
	input logic signed [POS_W-1:0]  view_z,
	input logic [COLOR_W-1:0]       out_red,
	input logic [COLOR_W-1:0]       out_green,
	input logic [COLOR_W-1:0]       out_blue
);

	// No vertex transfer while a register write is in progress or just after
	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input accepted right after a configuration write");

	a_cfg_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("input accepted in the cycle of a configuration write");

	// An empty output with settled matrices must let a vertex in
	a_empty_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !cfg_we && !$past(cfg_we) && !$past(cfg_we, 2)
			&& $past(arst_n) && $past(arst_n, 2)) |-> in_ready)
		else $error("input stalled while the output stage is empty");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(view_x)
			&& $stable(view_y) && $stable(view_z) && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue)))
		else $error("stalled result changed or dropped");

endmodule

bind vertex_model_view_transform vmv_checker u_vmv_checker (.*);
